>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the byte pipe RTL.
// Users must have clk and rst_n (synchronous, active low) in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define BPRB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define BPRB_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> hw/rtl/bprb_pkg.sv
// Types and constants for the byte pipe ring buffer.
// No dependencies; used by every other file of the block but assert_macros.svh.
package bprb_pkg;

  localparam int KIND_W  = 3;
  localparam int BYTE_W  = 8;
  localparam int CNT_W   = 7;
  localparam int STAT_W  = 2;

  // input kind codes
  localparam logic [KIND_W-1:0] KIND_OPEN     = 3'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_READ     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLOSE_RD = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CLOSE_WR = 3'd4;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [2:0] {
    OP_OPEN,
    OP_WRITE,
    OP_READ,
    OP_CLOSE_RD,
    OP_CLOSE_WR
  } bprb_op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK,
    ST_RETRY,
    ST_BROKEN,
    ST_MISUSE
  } bprb_status_t;

  typedef struct packed {
    bprb_op_t            op;
    logic [BYTE_W-1:0]   data;
    logic [CNT_W-1:0]    count;   // already saturated to MAX_READ
  } bprb_cmd_t;

endpackage

>>> hw/rtl/bprb_in_if.sv
// Input channel of the byte pipe: valid/ready plus one operation word.
// Depends on bprb_pkg for field widths.
interface bprb_in_if;
  logic                         valid;
  logic                         ready;
  logic [bprb_pkg::KIND_W-1:0]  kind;
  logic [bprb_pkg::BYTE_W-1:0]  data_in;
  logic [bprb_pkg::CNT_W-1:0]   read_count;

  modport source (output valid, kind, data_in, read_count, input ready);
  modport sink   (input valid, kind, data_in, read_count, output ready);
endinterface

>>> hw/rtl/bprb_out_if.sv
// Result channel of the byte pipe: valid/ready plus one result word.
// Depends on bprb_pkg for field widths.
interface bprb_out_if;
  logic                         valid;
  logic                         ready;
  logic [bprb_pkg::STAT_W-1:0]  status;
  logic [bprb_pkg::BYTE_W-1:0]  data_out;
  logic                         data_valid;
  logic                         last;
  logic                         freed;

  modport source (output valid, status, data_out, data_valid, last, freed, input ready);
  modport sink   (input valid, status, data_out, data_valid, last, freed, output ready);
endinterface

>>> hw/rtl/bprb_front.sv
// Front end: takes input words, decodes kind and clamps the read count.
// Depends on bprb_pkg and bprb_in_if; feeds bprb_queue.
module bprb_front #(
  parameter int MAX_READ = 64
) (
  bprb_in_if.sink                in_ch,
  input  logic                   q_full_i,
  output logic                   push_o,
  output bprb_pkg::bprb_cmd_t    push_cmd_o
);

  logic              known;
  bprb_pkg::bprb_op_t op;
  logic [bprb_pkg::CNT_W-1:0] cnt;

  localparam logic [bprb_pkg::CNT_W-1:0] MaxCnt = bprb_pkg::CNT_W'(MAX_READ);

  always_comb begin
    known = 1'b1;
    op    = bprb_pkg::OP_OPEN;
    unique case (in_ch.kind)
      bprb_pkg::KIND_OPEN:     op = bprb_pkg::OP_OPEN;
      bprb_pkg::KIND_WRITE:    op = bprb_pkg::OP_WRITE;
      bprb_pkg::KIND_READ:     op = bprb_pkg::OP_READ;
      bprb_pkg::KIND_CLOSE_RD: op = bprb_pkg::OP_CLOSE_RD;
      bprb_pkg::KIND_CLOSE_WR: op = bprb_pkg::OP_CLOSE_WR;
      default:                 known = 1'b0;  // taken and dropped
    endcase
  end

  assign cnt = (in_ch.read_count > MaxCnt) ? MaxCnt : in_ch.read_count;

  assign in_ch.ready      = !q_full_i;
  assign push_o           = in_ch.valid && !q_full_i && known;
  assign push_cmd_o.op    = op;
  assign push_cmd_o.data  = in_ch.data_in;
  assign push_cmd_o.count = cnt;

endmodule

>>> hw/rtl/bprb_queue.sv
// Two-entry command queue decoupling the front end from the executor.
// Depends on bprb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bprb_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_i,
  input  bprb_pkg::bprb_cmd_t   push_cmd_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output bprb_pkg::bprb_cmd_t   head_o
);

  bprb_pkg::bprb_cmd_t             entry_r [bprb_pkg::QUEUE_DEPTH];
  logic [bprb_pkg::QPTR_W-1:0]     wptr_r, wptr_nxt;
  logic [bprb_pkg::QPTR_W-1:0]     rptr_r, rptr_nxt;
  logic [bprb_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;

  localparam logic [bprb_pkg::QCNT_W-1:0] QFull =
    bprb_pkg::QCNT_W'(bprb_pkg::QUEUE_DEPTH);

  assign full_o  = (cnt_r == QFull);
  assign valid_o = (cnt_r != '0);
  assign head_o  = entry_r[rptr_r];

  always_comb begin
    wptr_nxt = push_i ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop_i  ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (push_i && !pop_i) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_i) begin
      entry_r[wptr_r] <= push_cmd_i;
    end
  end

  `BPRB_NEVER(a_q_overflow, push_i && !pop_i && (cnt_r == QFull), "queue overflow")
  `BPRB_NEVER(a_q_underflow, pop_i && (cnt_r == '0), "queue popped while empty")

endmodule

>>> hw/rtl/bprb_back.sv
// Executor: ring store, positions and end flags; runs one command at a time
// and streams results through a fetch stage and an output register.
// Depends on bprb_pkg, bprb_out_if and assert_macros.svh.
`include "assert_macros.svh"

module bprb_back #(
  parameter int PIPE_DEPTH = 512
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_valid_i,
  input  bprb_pkg::bprb_cmd_t   q_cmd_i,
  output logic                  q_pop_o,
  bprb_out_if.source            out_ch
);

  localparam int IDX_W  = (PIPE_DEPTH > 1) ? $clog2(PIPE_DEPTH) : 1;
  localparam int FILL_W = $clog2(PIPE_DEPTH + 1);
  localparam int CMP_W  = (FILL_W > bprb_pkg::CNT_W) ? FILL_W : bprb_pkg::CNT_W;
  localparam logic [IDX_W-1:0]  IdxLast = IDX_W'(PIPE_DEPTH - 1);
  localparam logic [FILL_W-1:0] DepthF  = FILL_W'(PIPE_DEPTH);

  logic [bprb_pkg::BYTE_W-1:0] ring_mem [PIPE_DEPTH];

  // positions: index within the store plus a lap bit
  logic [IDX_W-1:0] ridx_r, ridx_nxt, widx_r, widx_nxt;
  logic             rph_r, rph_nxt, wph_r, wph_nxt;
  logic             ro_r, ro_nxt, wo_r, wo_nxt;
  logic             busy_r, busy_nxt;
  logic [bprb_pkg::CNT_W-1:0] left_r, left_nxt;

  // fetch stage (byte comes from the store read register)
  logic                        f_v_r, f_v_nxt;
  bprb_pkg::bprb_status_t      f_status_r, f_status_nxt;
  logic                        f_dv_r, f_dv_nxt, f_last_r, f_last_nxt;
  logic                        f_freed_r, f_freed_nxt;
  logic [bprb_pkg::BYTE_W-1:0] rd_q_r;

  // output register
  logic                        o_v_r, o_v_nxt;
  bprb_pkg::bprb_status_t      o_status_r;
  logic [bprb_pkg::BYTE_W-1:0] o_data_r;
  logic                        o_dv_r, o_last_r, o_freed_r;

  logic              f_move, slot_free, issue, pop, mem_we;
  logic              empty, full;
  logic [FILL_W-1:0] avail;
  logic [CMP_W-1:0]  want_x, avail_x, n_x;

  assign f_move    = f_v_r && (!o_v_r || out_ch.ready);
  assign slot_free = !f_v_r || f_move;
  assign issue     = busy_r && slot_free;
  assign pop       = q_valid_i && !busy_r && slot_free;
  assign q_pop_o   = pop;

  assign empty = (rph_r == wph_r) && (ridx_r == widx_r);
  assign full  = (rph_r != wph_r) && (ridx_r == widx_r);
  assign avail = (rph_r == wph_r) ? FILL_W'(widx_r) - FILL_W'(ridx_r)
                                  : FILL_W'(widx_r) + DepthF - FILL_W'(ridx_r);
  assign want_x  = CMP_W'(q_cmd_i.count);
  assign avail_x = CMP_W'(avail);
  assign n_x     = (want_x < avail_x) ? want_x : avail_x;

  always_comb begin
    ridx_nxt     = ridx_r;
    rph_nxt      = rph_r;
    widx_nxt     = widx_r;
    wph_nxt      = wph_r;
    ro_nxt       = ro_r;
    wo_nxt       = wo_r;
    busy_nxt     = busy_r;
    left_nxt     = left_r;
    mem_we       = 1'b0;
    f_v_nxt      = f_v_r && !f_move;
    f_status_nxt = f_status_r;
    f_dv_nxt     = f_dv_r;
    f_last_nxt   = f_last_r;
    f_freed_nxt  = f_freed_r;

    if (issue) begin
      f_v_nxt      = 1'b1;
      f_status_nxt = bprb_pkg::ST_OK;
      f_dv_nxt     = 1'b1;
      f_last_nxt   = (left_r == bprb_pkg::CNT_W'(1));
      f_freed_nxt  = 1'b0;
      left_nxt     = left_r - 1'b1;
      busy_nxt     = (left_r != bprb_pkg::CNT_W'(1));
      if (ridx_r == IdxLast) begin
        ridx_nxt = '0;
        rph_nxt  = !rph_r;
      end else begin
        ridx_nxt = ridx_r + 1'b1;
      end
    end else if (pop) begin
      // single-word answer by default
      f_v_nxt      = 1'b1;
      f_status_nxt = bprb_pkg::ST_OK;
      f_dv_nxt     = 1'b0;
      f_last_nxt   = 1'b1;
      f_freed_nxt  = 1'b0;
      unique case (q_cmd_i.op)
        bprb_pkg::OP_OPEN: begin
          ridx_nxt = '0;
          rph_nxt  = 1'b0;
          widx_nxt = '0;
          wph_nxt  = 1'b0;
          ro_nxt   = 1'b1;
          wo_nxt   = 1'b1;
        end
        bprb_pkg::OP_WRITE: begin
          if (!wo_r) begin
            f_status_nxt = bprb_pkg::ST_MISUSE;
          end else if (!ro_r) begin
            f_status_nxt = bprb_pkg::ST_BROKEN;
          end else if (full) begin
            f_status_nxt = bprb_pkg::ST_RETRY;
          end else begin
            mem_we = 1'b1;
            if (widx_r == IdxLast) begin
              widx_nxt = '0;
              wph_nxt  = !wph_r;
            end else begin
              widx_nxt = widx_r + 1'b1;
            end
          end
        end
        bprb_pkg::OP_READ: begin
          if (!ro_r) begin
            f_status_nxt = bprb_pkg::ST_MISUSE;
          end else if (empty) begin
            f_status_nxt = wo_r ? bprb_pkg::ST_RETRY : bprb_pkg::ST_BROKEN;
          end else if (n_x != '0) begin
            // bytes are issued while busy, whenever the fetch slot is free
            f_v_nxt  = f_v_r && !f_move;
            busy_nxt = 1'b1;
            left_nxt = bprb_pkg::CNT_W'(n_x);
          end
        end
        bprb_pkg::OP_CLOSE_RD: begin
          if (!ro_r) begin
            f_status_nxt = bprb_pkg::ST_MISUSE;
          end else begin
            ro_nxt      = 1'b0;
            f_freed_nxt = !wo_r;
          end
        end
        bprb_pkg::OP_CLOSE_WR: begin
          if (!wo_r) begin
            f_status_nxt = bprb_pkg::ST_MISUSE;
          end else begin
            wo_nxt      = 1'b0;
            f_freed_nxt = !ro_r;
          end
        end
        default: f_v_nxt = f_v_r && !f_move;
      endcase
    end
  end

  assign o_v_nxt = f_move || (o_v_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ridx_r <= '0;
      rph_r  <= 1'b0;
      widx_r <= '0;
      wph_r  <= 1'b0;
      ro_r   <= 1'b1;
      wo_r   <= 1'b1;
      busy_r <= 1'b0;
      left_r <= '0;
      f_v_r  <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      ridx_r <= ridx_nxt;
      rph_r  <= rph_nxt;
      widx_r <= widx_nxt;
      wph_r  <= wph_nxt;
      ro_r   <= ro_nxt;
      wo_r   <= wo_nxt;
      busy_r <= busy_nxt;
      left_r <= left_nxt;
      f_v_r  <= f_v_nxt;
      o_v_r  <= o_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    f_status_r <= f_status_nxt;
    f_dv_r     <= f_dv_nxt;
    f_last_r   <= f_last_nxt;
    f_freed_r  <= f_freed_nxt;
    if (f_move) begin
      o_status_r <= f_status_r;
      o_data_r   <= f_dv_r ? rd_q_r : '0;
      o_dv_r     <= f_dv_r;
      o_last_r   <= f_last_r;
      o_freed_r  <= f_freed_r;
    end
  end

  // ring store: one write port, one registered read port held while stalled
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[widx_r] <= q_cmd_i.data;
    end
    if (issue) begin
      rd_q_r <= ring_mem[ridx_r];
    end
  end

  assign out_ch.valid      = o_v_r;
  assign out_ch.status     = o_status_r;
  assign out_ch.data_out   = o_data_r;
  assign out_ch.data_valid = o_dv_r;
  assign out_ch.last       = o_last_r;
  assign out_ch.freed      = o_freed_r;

  `BPRB_ASSERT(a_busy_left, busy_r |-> (left_r != '0), "read busy with nothing left")
  `BPRB_NEVER(a_fill_bound, (rph_r != wph_r) && (widx_r > ridx_r), "fill above depth")
  `BPRB_ASSERT(a_issue_load, issue |=> (f_v_r && f_dv_r), "issued byte not in fetch stage")

endmodule

>>> hw/rtl/byte_pipe_ring_buffer.sv
// Byte pipe over a ring store: front decode, 2-word command queue, executor.
// Open, write and close answer via the queue, fetch stage and output register;
// a read of n bytes then streams its bytes, one per cycle while out_ch is ready.
// Executor: one non-read word per cycle unless out_ch stalls; a read holds it to its last byte.
// Reset (rst_n low, synchronous): positions 0, both ends open, queue empty;
// the store itself is not cleared.
module byte_pipe_ring_buffer #(
  parameter int PIPE_DEPTH = 512,
  parameter int MAX_READ   = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  bprb_in_if.sink     in_ch,
  bprb_out_if.source  out_ch
);

  logic                 push, q_full, q_valid, q_pop;
  bprb_pkg::bprb_cmd_t  push_cmd, q_head;

  bprb_front #(
    .MAX_READ (MAX_READ)
  ) u_front (
    .in_ch      (in_ch),
    .q_full_i   (q_full),
    .push_o     (push),
    .push_cmd_o (push_cmd)
  );

  bprb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .valid_o    (q_valid),
    .head_o     (q_head)
  );

  bprb_back #(
    .PIPE_DEPTH (PIPE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_head),
    .q_pop_o   (q_pop),
    .out_ch    (out_ch)
  );

endmodule

>>> dv/tb_top.sv
// Self-checking bench for byte_pipe_ring_buffer: drives operation words on in_ch,
// predicts the result words from a shadow copy of the pipe, checks what out_ch gives.
// Depends on bprb_pkg, bprb_in_if, bprb_out_if and the block itself.
module tb_top;

  localparam int KIND_W      = bprb_pkg::KIND_W;
  localparam int BYTE_W      = bprb_pkg::BYTE_W;
  localparam int CNT_W       = bprb_pkg::CNT_W;
  localparam int PIPE_DEPTH  = 512;
  localparam int MAX_READ    = 64;
  localparam int POS_W       = $clog2(2 * PIPE_DEPTH);
  localparam int KIND_MAX    = (1 << KIND_W) - 1;
  localparam int COUNT_MAX   = (1 << CNT_W) - 1;
  localparam int BYTE_MAX    = (1 << BYTE_W) - 1;
  localparam int IDLE_PCT    = 25;
  localparam int RANDOM_OPS  = 60;
  localparam int FILL_ROUNDS = 1;
  localparam int DRAIN_WAIT  = 100;
  localparam int PRINT_CAP   = 40;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data;
    logic [CNT_W-1:0]  count;
  } pipe_op_t;

  typedef struct {
    bprb_pkg::bprb_status_t status;
    logic [BYTE_W-1:0]      data;
    logic                   dvalid;
    logic                   last;
    logic                   freed;
  } pipe_word_t;

  logic clk;
  logic rst_n = 1'b0;
  logic gaps_on = 1'b1;
  logic in_fire = 1'b0;
  int   err_count = 0;
  int   ops_queued = 0;
  int   ops_taken = 0;

  pipe_op_t   op_backlog[$];
  pipe_word_t pending_words[$];

  // shadow of the pipe state
  logic [BYTE_W-1:0] shadow_ring [PIPE_DEPTH];
  logic [POS_W-1:0]  shadow_rd;
  logic [POS_W-1:0]  shadow_wr;
  logic              shadow_rd_open;
  logic              shadow_wr_open;

  bprb_in_if  in_ch ();
  bprb_out_if out_ch ();

  byte_pipe_ring_buffer #(
    .PIPE_DEPTH (PIPE_DEPTH),
    .MAX_READ   (MAX_READ)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #16_000_000;
    $display("FAIL byte_pipe_ring_buffer");
    $finish;
  end

  task automatic report_mismatch(string msg);
    err_count++;
    if (err_count <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  function automatic void add_word(bprb_pkg::bprb_status_t st, logic [BYTE_W-1:0] d,
                                   logic dv, logic lst, logic fr);
    pipe_word_t w;
    w.status = st;
    w.data   = d;
    w.dvalid = dv;
    w.last   = lst;
    w.freed  = fr;
    pending_words.push_back(w);
  endfunction

  function automatic void predict_pipe_words(pipe_op_t op);
    logic [POS_W-1:0] fill;
    int want;
    int n;
    fill = shadow_wr - shadow_rd;
    case (op.kind)
      bprb_pkg::KIND_OPEN: begin
        shadow_rd      = '0;
        shadow_wr      = '0;
        shadow_rd_open = 1'b1;
        shadow_wr_open = 1'b1;
        add_word(bprb_pkg::ST_OK, '0, 1'b0, 1'b1, 1'b0);
      end
      bprb_pkg::KIND_WRITE: begin
        // writer state is checked before reader state, then fullness
        if (!shadow_wr_open) add_word(bprb_pkg::ST_MISUSE, '0, 1'b0, 1'b1, 1'b0);
        else if (!shadow_rd_open) add_word(bprb_pkg::ST_BROKEN, '0, 1'b0, 1'b1, 1'b0);
        else if (fill >= PIPE_DEPTH) add_word(bprb_pkg::ST_RETRY, '0, 1'b0, 1'b1, 1'b0);
        else begin
          shadow_ring[shadow_wr[POS_W-2:0]] = op.data;
          shadow_wr = shadow_wr + 1'b1;
          add_word(bprb_pkg::ST_OK, '0, 1'b0, 1'b1, 1'b0);
        end
      end
      bprb_pkg::KIND_READ: begin
        if (!shadow_rd_open) add_word(bprb_pkg::ST_MISUSE, '0, 1'b0, 1'b1, 1'b0);
        else if (fill == 0)
          add_word(shadow_wr_open ? bprb_pkg::ST_RETRY : bprb_pkg::ST_BROKEN,
                   '0, 1'b0, 1'b1, 1'b0);
        else begin
          want = (op.count > MAX_READ) ? MAX_READ : int'(op.count);
          n = (want < fill) ? want : int'(fill);
          if (n == 0) add_word(bprb_pkg::ST_OK, '0, 1'b0, 1'b1, 1'b0);
          for (int i = 0; i < n; i++) begin
            add_word(bprb_pkg::ST_OK, shadow_ring[shadow_rd[POS_W-2:0]], 1'b1,
                     i == n - 1, 1'b0);
            shadow_rd = shadow_rd + 1'b1;
          end
        end
      end
      bprb_pkg::KIND_CLOSE_RD: begin
        if (!shadow_rd_open) add_word(bprb_pkg::ST_MISUSE, '0, 1'b0, 1'b1, 1'b0);
        else begin
          shadow_rd_open = 1'b0;
          add_word(bprb_pkg::ST_OK, '0, 1'b0, 1'b1, !shadow_wr_open);
        end
      end
      bprb_pkg::KIND_CLOSE_WR: begin
        if (!shadow_wr_open) add_word(bprb_pkg::ST_MISUSE, '0, 1'b0, 1'b1, 1'b0);
        else begin
          shadow_wr_open = 1'b0;
          add_word(bprb_pkg::ST_OK, '0, 1'b0, 1'b1, !shadow_rd_open);
        end
      end
      default: ;  // unknown kinds are dropped silently
    endcase
  endfunction

  // input acceptance feeds the predictor
  always @(posedge clk) begin
    in_fire = rst_n && in_ch.valid && in_ch.ready;
    if (!rst_n) begin
      shadow_rd      = '0;
      shadow_wr      = '0;
      shadow_rd_open = 1'b1;
      shadow_wr_open = 1'b1;
    end else if (in_fire) begin
      pipe_op_t op;
      op.kind  = in_ch.kind;
      op.data  = in_ch.data_in;
      op.count = in_ch.read_count;
      predict_pipe_words(op);
      ops_taken++;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      pipe_word_t w;
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word status %0d data %02h",
                                  out_ch.status, out_ch.data_out));
      end else begin
        w = pending_words.pop_front();
        if (out_ch.status !== w.status)
          report_mismatch($sformatf("status got %0d want %0d", out_ch.status, w.status));
        if (out_ch.data_out !== w.data)
          report_mismatch($sformatf("data_out got %02h want %02h", out_ch.data_out, w.data));
        if (out_ch.data_valid !== w.dvalid)
          report_mismatch($sformatf("data_valid got %b want %b", out_ch.data_valid, w.dvalid));
        if (out_ch.last !== w.last)
          report_mismatch($sformatf("last got %b want %b", out_ch.last, w.last));
        if (out_ch.freed !== w.freed)
          report_mismatch($sformatf("freed got %b want %b", out_ch.freed, w.freed));
      end
    end
  end

  // operation driver
  always @(negedge clk) begin
    pipe_op_t op;
    logic     next_valid;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      next_valid = 1'b0;
      if (op_backlog.size() != 0 && !(gaps_on && $urandom_range(99) < IDLE_PCT)) begin
        op = op_backlog.pop_front();
        in_ch.kind       <= op.kind;
        in_ch.data_in    <= op.data;
        in_ch.read_count <= op.count;
        next_valid = 1'b1;
      end
      in_ch.valid <= next_valid;
    end
  end

  // result sink back-pressure
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= !(gaps_on && $urandom_range(99) < IDLE_PCT);
  end

  task automatic queue_op(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data,
                          logic [CNT_W-1:0] count);
    pipe_op_t op;
    op.kind  = kind;
    op.data  = data;
    op.count = count;
    op_backlog.push_back(op);
    ops_queued++;
  endtask

  task automatic wait_drained();
    while (ops_taken != ops_queued || pending_words.size() != 0) @(negedge clk);
  endtask

  task automatic queue_random_op();
    int pick;
    logic [CNT_W-1:0] cnt;
    logic [BYTE_W-1:0] rnd_data;
    logic [CNT_W-1:0] rnd_cnt;
    pick = $urandom_range(99);
    cnt = ($urandom_range(3) == 0) ? CNT_W'($urandom_range(COUNT_MAX))
                                   : CNT_W'($urandom_range(8));
    rnd_data = BYTE_W'($urandom);
    rnd_cnt  = CNT_W'($urandom);
    if (pick < 5) queue_op(bprb_pkg::KIND_OPEN, rnd_data, rnd_cnt);
    else if (pick < 50) queue_op(bprb_pkg::KIND_WRITE, rnd_data, rnd_cnt);
    else if (pick < 82) queue_op(bprb_pkg::KIND_READ, rnd_data, cnt);
    else if (pick < 88) queue_op(bprb_pkg::KIND_CLOSE_RD, rnd_data, rnd_cnt);
    else if (pick < 94) queue_op(bprb_pkg::KIND_CLOSE_WR, rnd_data, rnd_cnt);
    else queue_op(KIND_W'($urandom_range(bprb_pkg::KIND_CLOSE_WR + 1, KIND_MAX)),
                  rnd_data, rnd_cnt);
  endtask

  initial begin
    int left;
    int cnt;
    in_ch.valid      = 1'b0;
    in_ch.kind       = bprb_pkg::KIND_OPEN;
    in_ch.data_in    = '0;
    in_ch.read_count = '0;
    out_ch.ready     = 1'b0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty reads, byte extremes, saturation, unknown kinds, closes
    queue_op(bprb_pkg::KIND_READ, 8'h00, 7'd5);
    queue_op(bprb_pkg::KIND_READ, 8'h00, 7'd0);
    queue_op(bprb_pkg::KIND_WRITE, 8'h00, 7'd0);
    queue_op(bprb_pkg::KIND_WRITE, 8'hFF, 7'd0);
    queue_op(bprb_pkg::KIND_WRITE, 8'hA5, 7'd0);
    queue_op(bprb_pkg::KIND_READ, 8'h00, 7'd0);
    queue_op(bprb_pkg::KIND_READ, 8'h00, CNT_W'(COUNT_MAX));
    queue_op(bprb_pkg::KIND_WRITE, 8'h5A, 7'd0);
    queue_op(bprb_pkg::KIND_READ, 8'h00, 7'd1);
    for (int k = bprb_pkg::KIND_CLOSE_WR + 1; k <= KIND_MAX; k++)
      queue_op(KIND_W'(k), BYTE_W'(BYTE_MAX), CNT_W'(COUNT_MAX));
    queue_op(bprb_pkg::KIND_WRITE, 8'h81, 7'd0);
    queue_op(bprb_pkg::KIND_CLOSE_WR, 8'h00, 7'd0);
    queue_op(bprb_pkg::KIND_WRITE, 8'h11, 7'd0);
    queue_op(bprb_pkg::KIND_READ, 8'h00, 7'd64);  // drains the last byte with the writer gone
    queue_op(bprb_pkg::KIND_READ, 8'h00, 7'd64);
    queue_op(bprb_pkg::KIND_CLOSE_WR, 8'h00, 7'd0);
    queue_op(bprb_pkg::KIND_OPEN, 8'h00, 7'd0);
    queue_op(bprb_pkg::KIND_WRITE, 8'h3C, 7'd0);
    queue_op(bprb_pkg::KIND_CLOSE_RD, 8'h00, 7'd0);
    queue_op(bprb_pkg::KIND_WRITE, 8'hC3, 7'd0);
    queue_op(bprb_pkg::KIND_READ, 8'h00, 7'd2);
    queue_op(bprb_pkg::KIND_CLOSE_RD, 8'h00, 7'd0);
    queue_op(bprb_pkg::KIND_CLOSE_WR, 8'h00, 7'd0);
    queue_op(bprb_pkg::KIND_WRITE, 8'h7E, 7'd0);
    queue_op(bprb_pkg::KIND_OPEN, 8'h00, 7'd0);
    wait_drained();

    // fill to full and drain so both positions wrap
    for (int r = 0; r < FILL_ROUNDS; r++) begin
      gaps_on = (r != 0);
      for (int i = 0; i < PIPE_DEPTH; i++)
        queue_op(bprb_pkg::KIND_WRITE, BYTE_W'($urandom), CNT_W'($urandom));
      queue_op(bprb_pkg::KIND_WRITE, BYTE_W'($urandom), CNT_W'($urandom));
      queue_op(bprb_pkg::KIND_WRITE, BYTE_W'($urandom), CNT_W'($urandom));
      queue_op(bprb_pkg::KIND_READ, BYTE_W'($urandom), 7'd0);
      left = PIPE_DEPTH;
      while (left > 0) begin
        cnt = $urandom_range(1, COUNT_MAX);
        queue_op(bprb_pkg::KIND_READ, BYTE_W'($urandom), CNT_W'(cnt));
        left -= (cnt > MAX_READ) ? MAX_READ : cnt;
      end
      queue_op(bprb_pkg::KIND_READ, BYTE_W'($urandom), CNT_W'($urandom));
    end
    gaps_on = 1'b1;
    // hold the sender until the pipe has answered everything
    wait_drained();

    queue_op(bprb_pkg::KIND_OPEN, BYTE_W'($urandom), CNT_W'($urandom));
    for (int i = 0; i < RANDOM_OPS; i++) queue_random_op();

    wait_drained();
    repeat (DRAIN_WAIT) @(negedge clk);
    if (err_count == 0 && pending_words.size() == 0) begin
      $display("PASS byte_pipe_ring_buffer");
    end else begin
      $display("FAIL byte_pipe_ring_buffer");
    end
    $finish;
  end

endmodule
